// ----- src/gapp_pkg.sv -----
package gapp_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int SAMPLE_BITS = 8;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SUM_W       = SAMPLE_BITS + 2;
  localparam int GATE_W      = 13;
  localparam int BEAM_W      = 8;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET   = 8'd128;
  localparam logic [CFG_W-1:0]       MERGE_RESET       = 13'd8;
  localparam logic [CFG_W-1:0]       POINT_COUNT_RESET = 13'd4096;

  typedef struct packed {
    logic                     beam_end;
    logic [GATE_W-1:0]        gate_length;
    logic signed [GATE_W-1:0] gate_first;
    logic [BEAM_W-1:0]        beam_id;
    logic [SAMPLE_BITS-1:0]   amplitude;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] threshold;
    logic [CFG_W-1:0]       merge_distance;
    logic [CFG_W-1:0]       point_count;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic [SUM_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic                   last;
    logic [BEAM_W-1:0]      beam;
    logic [SAMPLE_BITS-1:0] amp;
    logic [IDX_W-1:0]       pos;
  } peak_t;

  typedef struct packed {
    logic [1:0] cnt;
    peak_t      first;
    peak_t      second;
  } push_t;

endpackage

// ----- src/gapp_tie_mem.sv -----
module gapp_tie_mem (
  input  logic                             clk,
  input  logic                             we,
  input  logic [gapp_pkg::IDX_W-1:0]       waddr,
  input  gapp_pkg::entry_t                 wdata,
  input  logic [gapp_pkg::IDX_W-1:0]       raddr,
  output gapp_pkg::entry_t                 rdata
);

  gapp_pkg::entry_t mem [gapp_pkg::MAX_POINTS];
  gapp_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/gapp_out_fifo.sv -----
module gapp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  gapp_pkg::push_t   push,
  output logic              room_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output gapp_pkg::peak_t   out_peak
);

  localparam int PTR_W = $clog2(gapp_pkg::FIFO_DEPTH);
  localparam int LVL_W = $clog2(gapp_pkg::FIFO_DEPTH + 1);

  gapp_pkg::peak_t   q_r [gapp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  level_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level_r != '0);
  assign out_peak  = q_r[rd_ptr_r];
  assign room_ok   = (level_r <= LVL_W'(gapp_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    level_nxt  = level_r + LVL_W'(push.cnt) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(gapp_pkg::FIFO_DEPTH))
    else $error("output queue level exceeds its depth");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room_ok)
    else $error("peak pushed without room in the output queue");

endmodule

// ----- src/gapp_core.sv -----
module gapp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gapp_pkg::in_item_t  in_item,
  input  gapp_pkg::cfg_t      cfg,
  input  logic                room_ok,
  output gapp_pkg::push_t     push
);

  localparam int IW = gapp_pkg::IDX_W;
  localparam int CW = gapp_pkg::CNT_W;
  localparam int SW = gapp_pkg::SUM_W;
  localparam int AW = gapp_pkg::SAMPLE_BITS;
  localparam int BW = gapp_pkg::BEAM_W;
  localparam int GW = gapp_pkg::GATE_W + 2;

  logic                s1_valid_r;
  gapp_pkg::in_item_t  s1_item_r;
  logic                s1_go;

  logic [IW-1:0]       idx_r,       idx_nxt;
  logic [AW-1:0]       prev_r,      prev_nxt;
  logic                in_run_r,    in_run_nxt;
  logic [AW-1:0]       max_r,       max_nxt;
  logic [CW-1:0]       tie_cnt_r,   tie_cnt_nxt;
  logic                pend_r,      pend_nxt;
  gapp_pkg::entry_t    tail_r,      tail_nxt;
  gapp_pkg::entry_t    ma_r,        ma_nxt;
  gapp_pkg::entry_t    mb_r,        mb_nxt;
  logic                held_v_r,    held_v_nxt;
  logic [IW-1:0]       held_pos_r,  held_pos_nxt;
  logic [AW-1:0]       held_amp_r,  held_amp_nxt;
  logic [BW-1:0]       held_beam_r, held_beam_nxt;

  logic [AW-1:0]       amp;
  logic signed [GW-1:0] gfirst_s;
  logic signed [GW-1:0] gend_s;
  logic signed [GW-1:0] gend_c;
  logic signed [GW-1:0] pc_s;
  logic signed [GW-1:0] idx_s;
  logic                in_gate;
  gapp_pkg::entry_t    tail_fin;
  gapp_pkg::entry_t    ma_eff;
  gapp_pkg::entry_t    mb_eff;
  gapp_pkg::entry_t    new_entry;
  gapp_pkg::entry_t    pick;
  gapp_pkg::entry_t    rd_data;
  logic [CW-1:0]       cur_cnt;
  logic [IW-1:0]       pos_gap;
  logic                offer;
  logic                res_a_v;
  logic                res_b_v;
  gapp_pkg::peak_t     res_a;
  gapp_pkg::peak_t     res_b;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [IW-1:0]       mem_raddr;

  assign s1_go    = s1_valid_r && room_ok;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  always_comb begin
    amp      = s1_item_r.amplitude;
    gfirst_s = GW'(s1_item_r.gate_first);
    gend_s   = gfirst_s + $signed({2'b00, s1_item_r.gate_length});
    pc_s     = $signed({2'b00, cfg.point_count});
    gend_c   = (gend_s > pc_s) ? pc_s : gend_s;
    idx_s    = $signed({3'b000, idx_r});
    in_gate  = (idx_s >= gfirst_s) && (idx_s < gend_c);

    // The newest tie learns its right neighbor from this item.
    tail_fin     = tail_r;
    tail_fin.sum = tail_r.sum + (pend_r ? SW'(amp) : SW'(0));
    ma_eff       = (pend_r && tie_cnt_r == CW'(1)) ? tail_fin : ma_r;
    mb_eff       = (pend_r && (tie_cnt_r == CW'(1) || tie_cnt_r == CW'(2))) ? tail_fin : mb_r;

    new_entry.pos = idx_r;
    new_entry.sum = SW'(prev_r) + SW'(amp);

    mem_we    = s1_go && pend_r && (tie_cnt_r != '0);
    mem_waddr = IW'(tie_cnt_r - CW'(1));

    idx_nxt       = idx_r + IW'(1);
    prev_nxt      = amp;
    in_run_nxt    = in_run_r;
    max_nxt       = max_r;
    tie_cnt_nxt   = tie_cnt_r;
    pend_nxt      = 1'b0;
    tail_nxt      = tail_fin;
    ma_nxt        = ma_eff;
    mb_nxt        = mb_eff;
    held_v_nxt    = held_v_r;
    held_pos_nxt  = held_pos_r;
    held_amp_nxt  = held_amp_r;
    held_beam_nxt = held_beam_r;
    cur_cnt       = tie_cnt_r;
    pick          = ma_eff;
    offer         = 1'b0;
    pos_gap       = '0;
    res_a_v       = 1'b0;
    res_b_v       = 1'b0;
    res_a         = '0;
    res_b         = '0;

    if (in_gate && (amp >= cfg.threshold)) begin
      in_run_nxt = 1'b1;
      if (amp > max_r) begin
        max_nxt = amp;
        cur_cnt = '0;
      end
      tie_cnt_nxt = cur_cnt;
      if ((amp >= max_r) && (cur_cnt < CW'(gapp_pkg::MAX_POINTS))) begin
        tail_nxt    = new_entry;
        pend_nxt    = 1'b1;
        tie_cnt_nxt = cur_cnt + CW'(1);
        if (cur_cnt == '0) begin
          ma_nxt = new_entry;
          mb_nxt = new_entry;
        end else if (!cur_cnt[0]) begin
          ma_nxt = mb_eff;
          mb_nxt = mb_eff;
        end else if (cur_cnt == CW'(1)) begin
          mb_nxt = new_entry;
        end else if (cur_cnt == CW'(3)) begin
          mb_nxt = tail_fin;
        end else begin
          mb_nxt = rd_data;
        end
      end
    end else begin
      if (in_gate && in_run_r && (tie_cnt_r != '0)) begin
        offer = 1'b1;
        if (!tie_cnt_r[0] && (mb_eff.sum > ma_eff.sum)) begin
          pick = mb_eff;
        end
      end
      in_run_nxt  = 1'b0;
      max_nxt     = '0;
      tie_cnt_nxt = '0;
    end

    if (offer) begin
      pos_gap = (pick.pos > held_pos_r) ? (pick.pos - held_pos_r) : (held_pos_r - pick.pos);
      if (held_v_r && ({1'b0, pos_gap} < cfg.merge_distance)) begin
        if (held_amp_r <= max_r) begin
          held_pos_nxt  = pick.pos;
          held_amp_nxt  = max_r;
          held_beam_nxt = s1_item_r.beam_id;
        end
      end else begin
        res_a_v       = held_v_r;
        res_a.pos     = held_pos_r;
        res_a.amp     = held_amp_r;
        res_a.beam    = held_beam_r;
        res_a.last    = 1'b0;
        held_v_nxt    = 1'b1;
        held_pos_nxt  = pick.pos;
        held_amp_nxt  = max_r;
        held_beam_nxt = s1_item_r.beam_id;
      end
    end

    if (s1_item_r.beam_end) begin
      res_b_v     = held_v_nxt;
      res_b.pos   = held_pos_nxt;
      res_b.amp   = held_amp_nxt;
      res_b.beam  = held_beam_nxt;
      res_b.last  = 1'b1;
      held_v_nxt  = 1'b0;
      idx_nxt     = '0;
      prev_nxt    = '0;
      in_run_nxt  = 1'b0;
      max_nxt     = '0;
      tie_cnt_nxt = '0;
      pend_nxt    = 1'b0;
    end

    if (!s1_go) begin
      tie_cnt_nxt = tie_cnt_r;
    end
    mem_raddr = IW'((tie_cnt_nxt + CW'(1)) >> 1);

    push.cnt    = s1_go ? (2'(res_a_v) + 2'(res_b_v)) : 2'd0;
    push.first  = res_a_v ? res_a : res_b;
    push.second = res_b;
  end

  gapp_tie_mem u_tie_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (tail_fin),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      prev_r    <= '0;
      in_run_r  <= 1'b0;
      max_r     <= '0;
      tie_cnt_r <= '0;
      pend_r    <= 1'b0;
      held_v_r  <= 1'b0;
    end else if (s1_go) begin
      idx_r     <= idx_nxt;
      prev_r    <= prev_nxt;
      in_run_r  <= in_run_nxt;
      max_r     <= max_nxt;
      tie_cnt_r <= tie_cnt_nxt;
      pend_r    <= pend_nxt;
      held_v_r  <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      tail_r      <= tail_nxt;
      ma_r        <= ma_nxt;
      mb_r        <= mb_nxt;
      held_pos_r  <= held_pos_nxt;
      held_amp_r  <= held_amp_nxt;
      held_beam_r <= held_beam_nxt;
    end
  end

  a_pend_has_tie: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (tie_cnt_r != '0))
    else $error("pending neighbor sum without a stored tie");

  a_beam_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_item_r.beam_end) |=> (!held_v_r && !in_run_r && idx_r == '0))
    else $error("beam end did not clear the peak and run state");

  a_tie_cap: assert property (@(posedge clk) disable iff (!rst_n)
    tie_cnt_r <= CW'(gapp_pkg::MAX_POINTS))
    else $error("tie count beyond the tie store depth");

endmodule

// ----- src/gated_ascan_peak_picker.sv -----
// Channel   Direction  Item fields
// in_*      slave      tdata: amplitude, beam_id, gate_first, gate_length; tlast: beam_end
// out_*     master     tdata: peak_position, peak_amplitude, peak_beam; tlast: last_of_beam
// cfg_*     write      index 0 threshold, 1 merge_distance, 2 point_count
//
// One sample item is taken per cycle with in_tready high; its peaks enter the output
// queue as the item leaves the input register. The input register and a four-deep
// output queue set the rate: in_tready falls only when the queue holds over two peaks.
// Reset clears the beam state and loads the register defaults; the tie store needs no
// clearing pass. Up to two peaks per item leave one per cycle with out_tready high.
module gated_ascan_peak_picker (
  input  logic                             clk,
  input  logic                             rst_n,
  // amplitude[7:0], beam_id[15:8], gate_first[28:16], gate_length[41:29], zero fill
  input  logic [47:0]                      in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // peak_position[11:0], peak_amplitude[19:12], peak_beam[27:20], zero fill
  output logic [31:0]                      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [gapp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gapp_pkg::CFG_W-1:0]       cfg_data
);

  gapp_pkg::cfg_t      cfg_r;
  gapp_pkg::in_item_t  item;
  gapp_pkg::push_t     push;
  gapp_pkg::peak_t     out_peak;
  logic                room_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= gapp_pkg::THRESHOLD_RESET;
      cfg_r.merge_distance <= gapp_pkg::MERGE_RESET;
      cfg_r.point_count    <= gapp_pkg::POINT_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gapp_pkg::REG_THRESHOLD: begin
          cfg_r.threshold <= cfg_data[gapp_pkg::SAMPLE_BITS-1:0];
        end
        gapp_pkg::REG_MERGE_DISTANCE: begin
          cfg_r.merge_distance <= cfg_data;
        end
        gapp_pkg::REG_POINT_COUNT: begin
          cfg_r.point_count <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.amplitude   = in_tdata[7:0];
    item.beam_id     = in_tdata[15:8];
    item.gate_first  = $signed(in_tdata[28:16]);
    item.gate_length = in_tdata[41:29];
    item.beam_end    = in_tlast;
  end

  gapp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (item),
    .cfg      (cfg_r),
    .room_ok  (room_ok),
    .push     (push)
  );

  gapp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_ok   (room_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_peak  (out_peak)
  );

  assign out_tdata = {4'b0000, out_peak.beam, out_peak.amp, out_peak.pos};
  assign out_tlast = out_peak.last;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int STALL_LIMIT  = 3000;
  localparam int PLATEAU_LEN  = 200;
  localparam int AW           = gapp_pkg::SAMPLE_BITS;
  localparam int IW           = gapp_pkg::IDX_W;
  localparam int SW           = gapp_pkg::SUM_W;
  localparam int GW           = gapp_pkg::GATE_W;
  localparam int BW           = gapp_pkg::BEAM_W;
  localparam int CIW          = gapp_pkg::CFG_IDX_W;
  localparam int CFW          = gapp_pkg::CFG_W;

  typedef struct {
    int              amp;
    int              beam;
    int              gfirst;
    int              glen;
    bit              last;
    bit              typed;
    int              n;
    gapp_pkg::peak_t p0;
    gapp_pkg::peak_t p1;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic [47:0]          in_tdata;
  logic                 in_tlast;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_we;
  logic [CIW-1:0]       cfg_index;
  logic [CFW-1:0]       cfg_data;

  // Register copies seen by the predictor, updated on each write.
  logic [AW-1:0]  thr_r   = gapp_pkg::THRESHOLD_RESET;
  logic [CFW-1:0] merge_r = gapp_pkg::MERGE_RESET;
  logic [CFW-1:0] pc_r    = gapp_pkg::POINT_COUNT_RESET;

  logic [IW-1:0]  sample_idx = '0;
  logic [AW-1:0]  last_amp   = '0;
  bit             run_open   = 1'b0;
  logic [AW-1:0]  run_peak   = '0;
  int             tie_n      = 0;
  logic [IW-1:0]  tie_at    [gapp_pkg::MAX_POINTS];
  logic [SW-1:0]  tie_total [gapp_pkg::MAX_POINTS];
  bit             right_due  = 1'b0;
  bit             hold_ok    = 1'b0;
  logic [IW-1:0]  hold_pos   = '0;
  logic [AW-1:0]  hold_amp   = '0;
  logic [BW-1:0]  hold_beam  = '0;

  gapp_pkg::peak_t fresh[$];
  gapp_pkg::peak_t peaks_due[$];

  int mismatches  = 0;
  int samples_in  = 0;
  int peaks_seen  = 0;
  int beams_sent  = 0;
  int idle_cycles = 0;
  int offered_row = -1;
  int src_idle    = 0;
  int sink_idle   = 0;
  int hold_len    = 0;
  bit hold_req    = 1'b0;
  int cur_thr     = 128;
  int cur_pc      = 4096;

  // threshold, merge distance, point count, sender idle %, receiver idle %, samples
  int plan [6][6] = '{
    '{100,    5,   64,  7, 74, 300},
    '{255,    0, 4096,  7, 74, 200},
    '{ 40, 4096,    1, 74,  7,  60},
    '{  1, 4096,  200, 74,  7, 300},
    '{128,    8, 4096,  0,  0, 100},
    '{ 60,    3,   32,  0,  0, 350}
  };

  dir_row_t dir_tab [24] = '{
    '{255,   0, -4096, 4096, 1'b0, 1'b1, 0, '0, '0},
    '{255,   0, -4096, 4096, 1'b1, 1'b1, 0, '0, '0},
    '{200, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{ 10, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{255, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{255, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{100, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{128, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{127, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{200, 255,     0, 4096, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 255,     0, 4096, 1'b1, 1'b1, 2,
      '{1'b0, 8'd255, 8'd255, 12'd3}, '{1'b1, 8'd255, 8'd200, 12'd11}},
    '{255,  90,     2,    3, 1'b0, 1'b0, 0, '0, '0},
    '{255,  90,     2,    3, 1'b0, 1'b0, 0, '0, '0},
    '{250,  90,     2,    3, 1'b0, 1'b0, 0, '0, '0},
    '{250,  90,     2,    3, 1'b0, 1'b0, 0, '0, '0},
    '{250,  90,     2,    3, 1'b0, 1'b0, 0, '0, '0},
    '{250,  90,     2,    3, 1'b1, 1'b1, 0, '0, '0},
    '{200, 165,     0,    3, 1'b0, 1'b0, 0, '0, '0},
    '{200, 165,     0,    3, 1'b0, 1'b0, 0, '0, '0},
    '{  0, 165,     0,    3, 1'b1, 1'b1, 1, '{1'b1, 8'd165, 8'd200, 12'd0}, '0}
  };

  gated_ascan_peak_picker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_run();
    run_open  = 1'b0;
    run_peak  = '0;
    tie_n     = 0;
    right_due = 1'b0;
  endfunction

  function automatic void predict_peaks(input gapp_pkg::in_item_t it);
    int amp, idx, gfirst, glen, gend, thr, pick, l, pos, gap;
    amp    = int'(it.amplitude);
    idx    = int'(sample_idx);
    gfirst = {{19{it.gate_first[GW-1]}}, it.gate_first};
    glen   = int'(it.gate_length);
    gend   = gfirst + glen;
    thr    = int'(thr_r);
    if (gend > int'(pc_r)) gend = int'(pc_r);

    if (right_due && tie_n > 0) tie_total[tie_n-1] = tie_total[tie_n-1] + SW'(amp);
    right_due = 1'b0;

    if (idx >= gfirst && idx < gend) begin
      if (amp >= thr) begin
        if (!run_open) begin
          clear_run();
          run_open = 1'b1;
        end
        if (amp > int'(run_peak)) begin
          run_peak = AW'(amp);
          tie_n    = 0;
        end
        if (amp == int'(run_peak) && tie_n < gapp_pkg::MAX_POINTS) begin
          tie_at[tie_n]    = IW'(idx);
          tie_total[tie_n] = SW'(amp + int'(last_amp));
          tie_n++;
          right_due = 1'b1;
        end
      end else if (run_open) begin
        if (tie_n > 0) begin
          if (tie_n % 2 == 1) begin
            pick = (tie_n - 1) / 2;
          end else begin
            l    = tie_n / 2 - 1;
            pick = (tie_total[l] >= tie_total[l+1]) ? l : l + 1;
          end
          pos = int'(tie_at[pick]);
          gap = (pos > int'(hold_pos)) ? pos - int'(hold_pos) : int'(hold_pos) - pos;
          // A close peak is dropped only when the held one is strictly larger.
          if (!(hold_ok && gap < int'(merge_r) && hold_amp > run_peak)) begin
            if (hold_ok && gap >= int'(merge_r))
              fresh.push_back('{1'b0, hold_beam, hold_amp, hold_pos});
            hold_ok   = 1'b1;
            hold_pos  = IW'(pos);
            hold_amp  = run_peak;
            hold_beam = it.beam_id;
          end
        end
        clear_run();
      end
    end else begin
      clear_run();
    end

    last_amp   = AW'(amp);
    sample_idx = sample_idx + IW'(1);

    if (it.beam_end) begin
      if (hold_ok) fresh.push_back('{1'b1, hold_beam, hold_amp, hold_pos});
      hold_ok    = 1'b0;
      sample_idx = '0;
      last_amp   = '0;
      clear_run();
    end
  endfunction

  always @(posedge clk) begin : monitor
    gapp_pkg::peak_t got, want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          gapp_pkg::REG_THRESHOLD:      thr_r   = cfg_data[AW-1:0];
          gapp_pkg::REG_MERGE_DISTANCE: merge_r = cfg_data;
          gapp_pkg::REG_POINT_COUNT:    pc_r    = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        samples_in++;
        predict_peaks({in_tlast, in_tdata[41:29], in_tdata[28:16], in_tdata[15:8],
                       in_tdata[7:0]});
        if (offered_row >= 0 && dir_tab[offered_row].typed) begin
          if (dir_tab[offered_row].n > 0) peaks_due.push_back(dir_tab[offered_row].p0);
          if (dir_tab[offered_row].n > 1) peaks_due.push_back(dir_tab[offered_row].p1);
        end else begin
          foreach (fresh[i]) peaks_due.push_back(fresh[i]);
        end
        fresh.delete();
      end

      if (out_tvalid && out_tready) begin
        peaks_seen++;
        got = '{out_tlast, out_tdata[27:20], out_tdata[19:12], out_tdata[11:0]};
        if (peaks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected peak pos %0d amp %0d beam %0d last %0b",
                                    got.pos, got.amp, got.beam, got.last));
        end else begin
          want = peaks_due.pop_front();
          if (got.pos !== want.pos || got.amp !== want.amp || got.beam !== want.beam ||
              got.last !== want.last)
            report_mismatch($sformatf(
              "peak got pos %0d amp %0d beam %0d last %0b, want %0d %0d %0d %0b",
              got.pos, got.amp, got.beam, got.last,
              want.pos, want.amp, want.beam, want.last));
        end
      end

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d peaks outstanding",
                 STALL_LIMIT, peaks_due.size());
        $display("** gated_ascan_peak_picker: FAILED **");
        $finish;
      end
    end
  end

  initial begin : sink_ctl
    int left;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (left = hold_len; left > 0; left--) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  task automatic send_sample(input gapp_pkg::in_item_t it, input int row);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    offered_row = row;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, it.gate_length, it.gate_first, it.beam_id, it.amplitude};
    in_tlast  <= it.beam_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input int thr, input int md, input int pc);
    cur_thr = thr;
    cur_pc  = pc;
    cfg_we    <= 1'b1;
    cfg_index <= gapp_pkg::REG_THRESHOLD;
    cfg_data  <= CFW'(thr);
    @(negedge clk);
    cfg_index <= gapp_pkg::REG_MERGE_DISTANCE;
    cfg_data  <= CFW'(md);
    @(negedge clk);
    cfg_index <= gapp_pkg::REG_POINT_COUNT;
    cfg_data  <= CFW'(pc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most beams keep one gate and a bumpy waveform with plateaus, so runs close and
  // peaks merge; noisy beams randomize every field on every item.
  task automatic send_beam(input bit noisy, inout int sent);
    gapp_pkg::in_item_t it;
    int len, top, gf, gl, a, i;
    top = (cur_pc + 8 < 300) ? cur_pc + 8 : 300;
    len = ($urandom_range(7) == 0) ? $urandom_range(top, 1) : $urandom_range(40, 2);
    gf  = ($urandom_range(3) == 0) ? -$urandom_range(12) : $urandom_range(len / 3);
    gl  = $urandom_range(len + 8);
    if ($urandom_range(9) == 0) begin
      gf = 0;
      gl = 4096;
    end
    a = 0;
    it.beam_id = BW'($urandom_range(255));
    for (i = 0; i < len; i++) begin
      if (noisy) begin
        it.amplitude   = AW'($urandom_range(255));
        it.beam_id     = BW'($urandom_range(255));
        it.gate_first  = GW'($urandom_range(8191));
        it.gate_length = GW'($urandom_range(4096));
        it.beam_end    = (i == len - 1) || ($urandom_range(30) == 0);
      end else begin
        case ($urandom_range(9))
          0, 1, 2: a = (cur_thr > 0) ? $urandom_range(cur_thr - 1) : 0;
          3, 4:    ;
          5, 6, 7: a = $urandom_range(255, cur_thr);
          8:       a = 255;
          default: a = $urandom_range(255);
        endcase
        it.amplitude   = AW'(a);
        it.gate_first  = GW'(gf);
        it.gate_length = GW'(gl);
        it.beam_end    = (i == len - 1);
      end
      send_sample(it, -1);
    end
    sent += len;
    beams_sent++;
  endtask

  initial begin : stimulus
    gapp_pkg::in_item_t it;
    int p, sent, i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = gapp_pkg::REG_THRESHOLD;
    cfg_data  = '0;
    src_idle  = 7;
    sink_idle = 74;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      it.amplitude   = AW'(dir_tab[r].amp);
      it.beam_id     = BW'(dir_tab[r].beam);
      it.gate_first  = GW'(dir_tab[r].gfirst);
      it.gate_length = GW'(dir_tab[r].glen);
      it.beam_end    = dir_tab[r].last;
      send_sample(it, r);
    end
    beams_sent += 4;

    for (p = 0; p < 6; p++) begin
      settle();
      set_config(plan[p][0], plan[p][1], plan[p][2]);
      src_idle  = plan[p][3];
      sink_idle = plan[p][4];
      if (p == 0) begin
        hold_len = 300;
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < plan[p][5]) send_beam($urandom_range(9) == 0, sent);
      if (p == 4) begin
        // One long plateau beam: many equal samples, so the middle tie moves through
        // the tie store.
        it.beam_id     = BW'($urandom_range(255));
        it.gate_first  = '0;
        it.gate_length = GW'(4096);
        for (i = 0; i < PLATEAU_LEN; i++) begin
          it.amplitude = (i == PLATEAU_LEN - 1) ? 8'd0 : 8'd200;
          it.beam_end  = (i == PLATEAU_LEN - 1);
          send_sample(it, -1);
        end
        beams_sent++;
      end
    end
    settle();

    $display("Covered %0d samples in %0d beams, %0d peaks checked, over six register",
             samples_in, beams_sent, peaks_seen);
    $display("settings with a long output stall and a long plateau beam.");
    if (mismatches == 0 && peaks_due.size() == 0) begin
      $display("** gated_ascan_peak_picker: PASSED **");
    end else begin
      $display("** gated_ascan_peak_picker: FAILED **");
    end
    $finish;
  end

endmodule
